// ===== sv/dfs_pkg.sv =====
// shared types, codes and defaults for the depth first search engine
package dfs_pkg;

  localparam int MAX_VERTICES_DEF = 1024;
  localparam int MAX_EDGES_DEF    = 8192;

  localparam int VTX_W   = 10;
  localparam int CFG_W   = 11;
  localparam int CNT_W   = 11;
  localparam int STAT_W  = 2;
  localparam int IN_W    = 32;
  localparam int OUT_W   = 24;

  localparam int LABEL_MAX = 1023;
  localparam int COUNT_MAX = 2047;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_ADD    = 2'd1,
    OP_SEARCH = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

endpackage

// ===== sv/dfs_ram.sv =====
// generic single write port ram with registered read
module dfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/depth_first_search_engine.sv =====
// depth first graph walk engine with per-vertex edge lists and an explicit stack
//
// channel   dir  width  contents (lowest bit up)
// cfg       in   11     cfg_data = vertex_count, written when cfg_we is high
// s_*       in   32     operation, edge_from, edge_to, vertex
// m_*       out  24     status, distance, reached, reached_count
//
// each item is carried through by the single sequencer that walks the list, edge,
// label and stack rams, and a new item is taken only while it is idle
// after reset a sweep over every vertex address zeroes the list and label rams,
// with s_tready low; a search sweeps the label ram the same way before it walks
// a result waiting on m_tready holds the next item after it in its final state
module depth_first_search_engine #(
  parameter int MAX_VERTICES = dfs_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = dfs_pkg::MAX_EDGES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [dfs_pkg::CFG_W-1:0]  cfg_data,   // vertex_count
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [dfs_pkg::IN_W-1:0]   s_tdata,    // operation, edge_from, edge_to, vertex
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [dfs_pkg::OUT_W-1:0]  m_tdata     // status, distance, reached, reached_count
);

  localparam int VW  = MAX_VERTICES > 1 ? $clog2(MAX_VERTICES) : 1;
  localparam int EW  = MAX_EDGES > 1 ? $clog2(MAX_EDGES) : 1;
  localparam int ESW = $clog2(MAX_EDGES + 1);
  localparam int SPW = $clog2(MAX_VERTICES + 1);
  localparam int XW  = dfs_pkg::VTX_W;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_ADD1, S_ADD2, S_SCLR, S_SINIT, S_POP, S_POPW,
    S_U, S_HCHK, S_EDGE, S_VIS, S_RD, S_OUT
  } state_t;

  state_t state;

  // registers
  logic [VW-1:0]   clr_idx;
  logic [ESW-1:0]  es;        // edges stored
  logic [SPW-1:0]  n_act;     // vertices in range
  logic [SPW-1:0]  sp;
  logic [SPW-1:0]  cnt;
  logic [XW-1:0]   fr;
  logic [XW-1:0]   tov;
  logic [XW-1:0]   vx;
  logic [EW-1:0]   head;
  logic [EW-1:0]   tail;
  logic            hv;
  logic [VW-1:0]   u;
  logic [XW-1:0]   nlab;
  logic [XW-1:0]   v;
  logic            v_ok;
  logic            more;
  logic [EW-1:0]   nxt;
  logic [dfs_pkg::STAT_W-1:0] res_status;
  logic [XW-1:0]   res_dist;
  logic            res_reach;
  logic [dfs_pkg::CNT_W-1:0]  res_cnt;

  // input fields
  dfs_pkg::op_t  in_op;
  logic [XW-1:0] in_from;
  logic [XW-1:0] in_to;
  logic [XW-1:0] in_vtx;
  logic          accept;
  logic          from_ok;
  logic          to_ok;
  logic          vtx_ok;
  logic          full;

  assign in_op   = dfs_pkg::op_t'(s_tdata[1:0]);
  assign in_from = s_tdata[11:2];
  assign in_to   = s_tdata[21:12];
  assign in_vtx  = s_tdata[31:22];
  assign s_tready = (state == S_IDLE);
  assign accept  = s_tvalid && s_tready;
  assign from_ok = 32'(in_from) < 32'(n_act);
  assign to_ok   = 32'(in_to) < 32'(n_act);
  assign vtx_ok  = 32'(in_vtx) < 32'(n_act);
  assign full    = 32'(es) >= 32'(MAX_EDGES);

  // ram ports
  logic            vr_we, vr_re;
  logic [VW-1:0]   vr_wa, vr_ra;
  logic [2*EW-1:0] vr_wd, vr_rd;        // head, tail
  logic            lb_we, lb_re;
  logic [VW-1:0]   lb_wa, lb_ra;
  logic [XW:0]     lb_wd, lb_rd;        // visited, label
  logic            tg_we, tg_re;
  logic [EW-1:0]   tg_wa, tg_ra;
  logic [2*XW-1:0] tg_wd, tg_rd;        // source, target
  logic            lk_we, lk_re;
  logic [EW-1:0]   lk_wa, lk_ra;
  logic [EW:0]     lk_wd, lk_rd;        // valid, link
  logic            sk_we, sk_re;
  logic [VW-1:0]   sk_wa, sk_ra;
  logic [VW-1:0]   sk_wd, sk_rd;

  logic [SPW-1:0]  sp_m1;
  logic            clr_last;
  logic            head_ok;
  logic            push;
  logic            add_linked;

  assign sp_m1    = sp - 1'b1;
  assign clr_last = clr_idx == VW'(MAX_VERTICES - 1);
  assign head_ok  = hv && (tg_rd[2*XW-1:XW] == XW'(u));
  assign push     = v_ok && !lb_rd[XW];

  // the source list already has a head when its stored head edge is live and
  // belongs to this source
  assign add_linked = hv && (tg_rd[2*XW-1:XW] == fr);

  always_comb begin
    vr_we = 1'b0; vr_wa = clr_idx; vr_wd = '0; vr_re = 1'b0; vr_ra = VW'(in_from);
    lb_we = 1'b0; lb_wa = clr_idx; lb_wd = '0; lb_re = 1'b0; lb_ra = VW'(in_vtx);
    tg_we = 1'b0; tg_wa = es[EW-1:0]; tg_wd = {fr, tov}; tg_re = 1'b0;
    tg_ra = vr_rd[2*EW-1:EW];
    lk_we = 1'b0; lk_wa = es[EW-1:0]; lk_wd = '0; lk_re = 1'b0;
    lk_ra = vr_rd[2*EW-1:EW];
    sk_we = 1'b0; sk_wa = sp[VW-1:0]; sk_wd = VW'(v); sk_re = 1'b0;
    sk_ra = sp_m1[VW-1:0];
    case (state)
      S_INIT: begin
        vr_we = 1'b1;
        lb_we = 1'b1;
      end
      S_IDLE: begin
        if (accept && in_op == dfs_pkg::OP_ADD) begin
          vr_re = 1'b1;
        end
        if (accept && in_op == dfs_pkg::OP_READ) begin
          lb_re = 1'b1;
        end
      end
      S_ADD1: begin
        tg_we = 1'b1;
        lk_we = 1'b1;
        tg_re = 1'b1;
      end
      S_ADD2: begin
        vr_we = 1'b1;
        vr_wa = VW'(fr);
        vr_wd = add_linked ? {head, es[EW-1:0]} : {es[EW-1:0], es[EW-1:0]};
        if (add_linked) begin
          lk_we = 1'b1;
          lk_wa = tail;
          lk_wd = {1'b1, es[EW-1:0]};
        end
      end
      S_SCLR: begin
        lb_we = 1'b1;
      end
      S_SINIT: begin
        lb_we = 1'b1;
        lb_wa = VW'(vx);
        lb_wd = {1'b1, XW'(0)};
        sk_we = 1'b1;
        sk_wa = '0;
        sk_wd = VW'(vx);
      end
      S_POP: begin
        sk_re = (sp != '0);
      end
      S_POPW: begin
        vr_re = 1'b1;
        vr_ra = sk_rd;
        lb_re = 1'b1;
        lb_ra = sk_rd;
      end
      S_U: begin
        tg_re = 1'b1;
        lk_re = 1'b1;
      end
      S_EDGE: begin
        lb_re = 1'b1;
        lb_ra = VW'(tg_rd[XW-1:0]);
      end
      S_VIS: begin
        if (push) begin
          lb_we = 1'b1;
          lb_wa = VW'(v);
          lb_wd = {1'b1, nlab};
          sk_we = 1'b1;
        end
        if (more) begin
          tg_re = 1'b1;
          tg_ra = nxt;
          lk_re = 1'b1;
          lk_ra = nxt;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      clr_idx  <= '0;
      es       <= '0;
      sp       <= '0;
      n_act    <= SPW'(MAX_VERTICES);
      m_tvalid <= 1'b0;
    end else begin
      // the output state itself refills the result register
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        if (32'(cfg_data) > 32'(MAX_VERTICES)) begin
          n_act <= SPW'(MAX_VERTICES);
        end else begin
          n_act <= SPW'(cfg_data);
        end
      end
      case (state)
        S_INIT: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_last) begin
            clr_idx <= '0;
            state   <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            fr         <= in_from;
            tov        <= in_to;
            vx         <= in_vtx;
            res_status <= dfs_pkg::ST_OK;
            res_dist   <= '0;
            res_reach  <= 1'b0;
            res_cnt    <= '0;
            case (in_op)
              dfs_pkg::OP_CLEAR: begin
                es    <= '0;
                state <= S_OUT;
              end
              dfs_pkg::OP_ADD: begin
                if (!from_ok || !to_ok) begin
                  res_status <= dfs_pkg::ST_RANGE;
                  state      <= S_OUT;
                end else if (full) begin
                  res_status <= dfs_pkg::ST_FULL;
                  state      <= S_OUT;
                end else begin
                  state <= S_ADD1;
                end
              end
              dfs_pkg::OP_SEARCH: begin
                if (!vtx_ok) begin
                  res_status <= dfs_pkg::ST_RANGE;
                  state      <= S_OUT;
                end else begin
                  clr_idx <= '0;
                  state   <= S_SCLR;
                end
              end
              dfs_pkg::OP_READ: begin
                if (!vtx_ok) begin
                  res_status <= dfs_pkg::ST_RANGE;
                  state      <= S_OUT;
                end else begin
                  state <= S_RD;
                end
              end
              default: begin
                state <= S_OUT;
              end
            endcase
          end
        end
        S_ADD1: begin
          head  <= vr_rd[2*EW-1:EW];
          tail  <= vr_rd[EW-1:0];
          hv    <= 32'(vr_rd[2*EW-1:EW]) < 32'(es);
          state <= S_ADD2;
        end
        S_ADD2: begin
          es    <= es + 1'b1;
          state <= S_OUT;
        end
        S_SCLR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_last) begin
            clr_idx <= '0;
            state   <= S_SINIT;
          end
        end
        S_SINIT: begin
          sp    <= SPW'(1);
          cnt   <= SPW'(1);
          state <= S_POP;
        end
        S_POP: begin
          if (sp == '0) begin
            res_cnt <= (32'(cnt) > dfs_pkg::COUNT_MAX) ?
                       dfs_pkg::CNT_W'(dfs_pkg::COUNT_MAX) : dfs_pkg::CNT_W'(cnt);
            state   <= S_OUT;
          end else begin
            sp    <= sp_m1;
            state <= S_POPW;
          end
        end
        S_POPW: begin
          u     <= sk_rd;
          state <= S_U;
        end
        S_U: begin
          nlab  <= (32'(lb_rd[XW-1:0]) >= dfs_pkg::LABEL_MAX) ?
                   XW'(dfs_pkg::LABEL_MAX) : lb_rd[XW-1:0] + 1'b1;
          hv    <= 32'(vr_rd[2*EW-1:EW]) < 32'(es);
          state <= S_HCHK;
        end
        S_HCHK: begin
          state <= head_ok ? S_EDGE : S_POP;
        end
        S_EDGE: begin
          v     <= tg_rd[XW-1:0];
          v_ok  <= 32'(tg_rd[XW-1:0]) < 32'(n_act);
          more  <= lk_rd[EW];
          nxt   <= lk_rd[EW-1:0];
          state <= S_VIS;
        end
        S_VIS: begin
          if (push) begin
            sp  <= sp + 1'b1;
            cnt <= cnt + 1'b1;
          end
          state <= more ? S_EDGE : S_POP;
        end
        S_RD: begin
          res_reach <= lb_rd[XW];
          res_dist  <= lb_rd[XW] ? lb_rd[XW-1:0] : '0;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {res_cnt, res_reach, res_dist, res_status};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // per vertex list head and tail
  dfs_ram #(.WIDTH(2*EW), .DEPTH(MAX_VERTICES)) u_vtx_ram (
    .clk(clk), .we(vr_we), .waddr(vr_wa), .wdata(vr_wd),
    .re(vr_re), .raddr(vr_ra), .rdata(vr_rd)
  );

  // visited flag and walk label
  dfs_ram #(.WIDTH(XW+1), .DEPTH(MAX_VERTICES)) u_lab_ram (
    .clk(clk), .we(lb_we), .waddr(lb_wa), .wdata(lb_wd),
    .re(lb_re), .raddr(lb_ra), .rdata(lb_rd)
  );

  // edge source and target
  dfs_ram #(.WIDTH(2*XW), .DEPTH(MAX_EDGES)) u_tgt_ram (
    .clk(clk), .we(tg_we), .waddr(tg_wa), .wdata(tg_wd),
    .re(tg_re), .raddr(tg_ra), .rdata(tg_rd)
  );

  // next edge link with valid bit
  dfs_ram #(.WIDTH(EW+1), .DEPTH(MAX_EDGES)) u_lnk_ram (
    .clk(clk), .we(lk_we), .waddr(lk_wa), .wdata(lk_wd),
    .re(lk_re), .raddr(lk_ra), .rdata(lk_rd)
  );

  // walk stack
  dfs_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_stk_ram (
    .clk(clk), .we(sk_we), .waddr(sk_wa), .wdata(sk_wd),
    .re(sk_re), .raddr(sk_ra), .rdata(sk_rd)
  );

endmodule

// ===== sv/dfs_checker.sv =====
// port level checks for the depth first search engine, bound to the top level
module dfs_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic [dfs_pkg::IN_W-1:0]   s_tdata,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [dfs_pkg::OUT_W-1:0]  m_tdata
);

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("item accepted while busy");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  a_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] == dfs_pkg::ST_RANGE) |->
    (m_tdata[23:2] == '0))
    else $error("range error with payload");

  a_unreached: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[12]) |-> (m_tdata[11:2] == '0))
    else $error("distance without reached");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] != 2'd3))
    else $error("undefined status");

endmodule

bind depth_first_search_engine dfs_checker u_dfs_checker (
  .clk(clk), .rst(rst),
  .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// ===== sim/tb.sv =====
// self-checking testbench for the depth first search engine
module tb;

  localparam int NV = dfs_pkg::MAX_VERTICES_DEF;
  localparam int NE = dfs_pkg::MAX_EDGES_DEF;

  // one expected result item, status in the lowest bits
  typedef struct packed {
    logic [dfs_pkg::CNT_W-1:0]  reached_count;
    logic                       reached;
    logic [dfs_pkg::VTX_W-1:0]  distance;
    logic [dfs_pkg::STAT_W-1:0] status;
  } walk_result_t;

  logic                       clk;
  logic                       rst;
  logic                       cfg_we;
  logic [dfs_pkg::CFG_W-1:0]  cfg_data;
  logic                       s_tvalid;
  logic                       s_tready;
  logic [dfs_pkg::IN_W-1:0]   s_tdata;    // operation, edge_from, edge_to, vertex
  logic                       m_tvalid;
  logic                       m_tready;
  logic [dfs_pkg::OUT_W-1:0]  m_tdata;    // status, distance, reached, reached_count

  depth_first_search_engine u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // mirror of the engine's graph and walk state
  logic [dfs_pkg::VTX_W-1:0] g_target [NE];
  logic [13:0]               g_link [NE];
  logic                      g_link_ok [NE];
  logic [13:0]               g_head [NV];
  logic                      g_head_ok [NV];
  logic [13:0]               g_tail [NV];
  int unsigned               g_stored;
  logic [dfs_pkg::VTX_W-1:0] g_label [NV];
  logic                      g_seen [NV];
  logic [dfs_pkg::VTX_W-1:0] g_stack [NV];
  logic [dfs_pkg::CFG_W-1:0] g_vcount;

  walk_result_t pending_results[$];
  int           errors = 0;
  int           burst_left;
  int unsigned  ready_cyc = 0;
  int           ready_mode = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    #100000000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int unsigned in_use();
    return (g_vcount > NV) ? NV : g_vcount;
  endfunction

  function automatic void graph_reset();
    for (int i = 0; i < NV; i++) begin
      g_head_ok[i] = 1'b0;
      g_seen[i]    = 1'b0;
    end
    g_stored = 0;
    g_vcount = dfs_pkg::CFG_W'(NV);
  endfunction

  // depth first walk from src, returns the saturated reached count
  function automatic int unsigned walk_from(int unsigned src);
    int unsigned n;
    int unsigned hits;
    int unsigned sp;
    int unsigned u;
    int unsigned e;
    int unsigned nxt;
    int unsigned v;
    logic        more;
    n    = in_use();
    hits = 1;
    for (int i = 0; i < NV; i++) g_seen[i] = 1'b0;
    g_seen[src]  = 1'b1;
    g_label[src] = '0;
    sp = 0;
    g_stack[sp] = dfs_pkg::VTX_W'(src);
    sp++;
    while (sp > 0) begin
      sp--;
      u    = g_stack[sp];
      nxt  = (g_label[u] >= dfs_pkg::LABEL_MAX) ? dfs_pkg::LABEL_MAX : g_label[u] + 1;
      more = g_head_ok[u];
      e    = g_head[u];
      while (more && e < NE) begin
        v = g_target[e];
        if (v < n && !g_seen[v]) begin
          g_seen[v]  = 1'b1;
          g_label[v] = dfs_pkg::VTX_W'(nxt);
          hits++;
          if (sp < NV) begin
            g_stack[sp] = dfs_pkg::VTX_W'(v);
            sp++;
          end
        end
        more = g_link_ok[e];
        e    = g_link[e];
      end
    end
    return (hits > dfs_pkg::COUNT_MAX) ? dfs_pkg::COUNT_MAX : hits;
  endfunction

  function automatic walk_result_t predict_walk_op(dfs_pkg::op_t op, int unsigned from,
                                                   int unsigned to, int unsigned vtx);
    walk_result_t r;
    int unsigned  n;
    int unsigned  e;
    r = '0;
    n = in_use();
    case (op)
      dfs_pkg::OP_CLEAR: begin
        for (int i = 0; i < NV; i++) g_head_ok[i] = 1'b0;
        g_stored = 0;
      end
      dfs_pkg::OP_ADD: begin
        if (from >= n || to >= n) begin
          r.status = dfs_pkg::ST_RANGE;
        end else if (g_stored >= NE) begin
          r.status = dfs_pkg::ST_FULL;
        end else begin
          e = g_stored;
          g_target[e]  = dfs_pkg::VTX_W'(to);
          g_link_ok[e] = 1'b0;
          if (g_head_ok[from]) begin
            g_link[g_tail[from]]    = 14'(e);
            g_link_ok[g_tail[from]] = 1'b1;
          end else begin
            g_head[from]    = 14'(e);
            g_head_ok[from] = 1'b1;
          end
          g_tail[from] = 14'(e);
          g_stored     = e + 1;
        end
      end
      dfs_pkg::OP_SEARCH: begin
        if (vtx >= n) r.status = dfs_pkg::ST_RANGE;
        else r.reached_count = dfs_pkg::CNT_W'(walk_from(vtx));
      end
      default: begin
        if (vtx >= n) begin
          r.status = dfs_pkg::ST_RANGE;
        end else if (g_seen[vtx]) begin
          r.distance = g_label[vtx];
          r.reached  = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  // sends one item in bursts with random gaps; called and returns at a falling edge
  task automatic send_item(dfs_pkg::op_t op, int unsigned from, int unsigned to,
                           int unsigned vtx);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    pending_results.push_back(predict_walk_op(op, from, to, vtx));
    s_tdata  <= {vtx[9:0], to[9:0], from[9:0], op};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // pause until every expected item has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_vertex_count(int unsigned value);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= value[dfs_pkg::CFG_W-1:0];
    @(negedge clk);
    cfg_we   <= 1'b0;
    g_vcount = value[dfs_pkg::CFG_W-1:0];
  endtask

  // receiver stall pattern, switching between four styles
  always @(negedge clk) begin
    ready_cyc++;
    if (ready_cyc % 300 == 0) ready_mode = $urandom_range(0, 3);
    case (ready_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= 1'($urandom_range(0, 1));
      2:       m_tready <= (ready_cyc % 7) < 4;
      default: m_tready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // result checker
  always @(posedge clk) begin
    walk_result_t want;
    walk_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual %h", $time, m_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          errors++;
        end
        if (got.distance !== want.distance) begin
          $display("%0t: distance expected %0d actual %0d", $time,
                   want.distance, got.distance);
          errors++;
        end
        if (got.reached !== want.reached) begin
          $display("%0t: reached expected %0d actual %0d", $time, want.reached, got.reached);
          errors++;
        end
        if (got.reached_count !== want.reached_count) begin
          $display("%0t: reached_count expected %0d actual %0d", $time,
                   want.reached_count, got.reached_count);
          errors++;
        end
      end
    end
  end

  // directed: every operation, bad vertices, stale edges, register extremes
  task automatic test_directed();
    send_item(dfs_pkg::OP_READ, 0, 0, 5);
    send_item(dfs_pkg::OP_ADD, 0, 1, 0);
    send_item(dfs_pkg::OP_ADD, 0, 2, 0);
    send_item(dfs_pkg::OP_ADD, 1, 3, 0);
    send_item(dfs_pkg::OP_ADD, 2, 3, 0);
    send_item(dfs_pkg::OP_ADD, 1023, 1023, 0);
    send_item(dfs_pkg::OP_SEARCH, 0, 0, 0);
    send_item(dfs_pkg::OP_READ, 0, 0, 3);
    send_item(dfs_pkg::OP_READ, 0, 0, 1023);
    send_item(dfs_pkg::OP_READ, 0, 0, 7);
    set_vertex_count(3);
    send_item(dfs_pkg::OP_ADD, 3, 0, 0);
    send_item(dfs_pkg::OP_ADD, 0, 3, 0);
    send_item(dfs_pkg::OP_SEARCH, 0, 0, 3);
    send_item(dfs_pkg::OP_READ, 0, 0, 3);
    send_item(dfs_pkg::OP_SEARCH, 0, 0, 0);
    send_item(dfs_pkg::OP_READ, 0, 0, 2);
    send_item(dfs_pkg::OP_CLEAR, 0, 0, 0);
    send_item(dfs_pkg::OP_READ, 0, 0, 2);
    set_vertex_count(0);
    send_item(dfs_pkg::OP_ADD, 0, 0, 0);
    send_item(dfs_pkg::OP_SEARCH, 0, 0, 0);
    send_item(dfs_pkg::OP_READ, 0, 0, 0);
    set_vertex_count(2047);
    send_item(dfs_pkg::OP_ADD, 1023, 0, 0);
    send_item(dfs_pkg::OP_SEARCH, 0, 0, 1023);
    send_item(dfs_pkg::OP_READ, 0, 0, 0);
    set_vertex_count(1);
    send_item(dfs_pkg::OP_ADD, 0, 0, 0);
    send_item(dfs_pkg::OP_SEARCH, 0, 0, 0);
  endtask

  // a chain through every vertex gives the deepest labels and the largest count
  task automatic test_long_chain();
    set_vertex_count(NV);
    send_item(dfs_pkg::OP_CLEAR, 0, 0, 0);
    for (int i = 0; i < NV - 1; i++) send_item(dfs_pkg::OP_ADD, i, i + 1, 0);
    send_item(dfs_pkg::OP_SEARCH, 0, 0, 0);
    send_item(dfs_pkg::OP_READ, 0, 0, 1023);
    send_item(dfs_pkg::OP_READ, 0, 0, 512);
  endtask

  // random phases: mostly in-range graph building and walks, some noise
  task automatic test_random(int unsigned total);
    int unsigned n;
    int unsigned sent;
    int unsigned pick;
    sent = 0;
    while (sent < total) begin
      case ($urandom_range(0, 5))
        0:       n = $urandom_range(1, 8);
        1:       n = (($urandom_range(0, 1)) != 0) ? NV : $urandom_range(1000, 2047);
        default: n = $urandom_range(9, 96);
      endcase
      set_vertex_count(n);
      if (n > NV) n = NV;
      if ($urandom_range(0, 2) == 0) send_item(dfs_pkg::OP_CLEAR, 0, 0, 0);
      for (int k = 0; k < 100 && sent < total; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55)
          send_item(dfs_pkg::OP_ADD, $urandom_range(0, n - 1), $urandom_range(0, n - 1), 0);
        else if (pick < 66)
          send_item(dfs_pkg::OP_SEARCH, 0, 0, $urandom_range(0, n - 1));
        else if (pick < 88)
          send_item(dfs_pkg::OP_READ, 0, 0, $urandom_range(0, n - 1));
        else if (pick < 90)
          send_item(dfs_pkg::OP_CLEAR, 0, 0, 0);
        else begin
          pick = $urandom();
          if (pick[1:0] == dfs_pkg::OP_SEARCH && pick[31:22] < n && n > 200)
            pick[1:0] = dfs_pkg::OP_READ;
          send_item(dfs_pkg::op_t'(pick[1:0]), pick[11:2], pick[21:12], pick[31:22]);
        end
        sent++;
        if (k == 50 && $urandom_range(0, 3) == 0) drain();
      end
    end
  endtask

  initial begin
    burst_left = 0;
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_data   = '0;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    graph_reset();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_long_chain();
    test_random(250);
    drain();
    repeat (50) @(negedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
